/* rtl/timed_priority_scene_selector_defines.svh */
// assertion helpers shared by the selector rtl
`ifndef TIMED_PRIORITY_SCENE_SELECTOR_DEFINES_SVH
`define TIMED_PRIORITY_SCENE_SELECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define TPSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define TPSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tpss_pkg.sv */
package tpss_pkg;

    // sizes and defaults
    localparam int NUM_SLOTS_DEF  = 10;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int SLOT_W         = 4;
    localparam int PRIO_W         = 8;
    localparam int CFG_W          = 40;
    localparam int CFG_IDX_W      = 1;
    localparam int FIELD_TIME_W   = 32;
    localparam int OP_W           = 2;

    // input request tdata layout
    localparam int SLOT_LSB       = 0;
    localparam int DUR_LSB        = SLOT_LSB + SLOT_W;
    localparam int NOW_LSB        = DUR_LSB + FIELD_TIME_W;
    localparam int IN_TDATA_W     = 72;

    // output request tdata layout
    localparam int OUT_SEL_LSB    = 0;
    localparam int OUT_CHG_BIT    = SLOT_W;
    localparam int OUT_TDATA_W    = 8;

    // priority register reset values
    localparam logic [CFG_W-1:0] PRIO_LO_RESET = 40'h46_5050_5A00;
    localparam logic [CFG_W-1:0] PRIO_HI_RESET = 40'h64_3228_3C3C;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_LO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_HI = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_EVAL       = 2'd0,
        OP_ACTIVATE   = 2'd1,
        OP_DEACTIVATE = 2'd2,
        OP_CLEAR      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_FIXUP,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic hit;
        logic activate;
        logic deactivate;
        logic clear;
        logic expire;
        logic set_idle;
    } t_cell_ctrl;

endpackage

/* rtl/tpss_cell.sv */
module tpss_cell
    import tpss_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [TIME_WIDTH-1:0] i_time,
    input  logic [TIME_WIDTH-1:0] i_dur,
    input  logic [PRIO_W-1:0]     i_prio,
    input  logic [PRIO_W-1:0]     i_best,
    input  logic [SLOT_W-1:0]     i_sel,
    output logic                  o_active,
    output logic [PRIO_W-1:0]     o_best,
    output logic [SLOT_W-1:0]     o_sel
);

    localparam logic IS_IDLE_SLOT = (CELL_IDX == 0);

    logic                  r_active;
    logic                  n_active;
    logic [TIME_WIDTH-1:0] r_start;
    logic [TIME_WIDTH-1:0] n_start;
    logic [TIME_WIDTH-1:0] r_life;
    logic [TIME_WIDTH-1:0] n_life;
    logic [PRIO_W-1:0]     r_best;
    logic [PRIO_W-1:0]     n_best;
    logic [SLOT_W-1:0]     r_sel;
    logic [SLOT_W-1:0]     n_sel;
    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_timed_out;
    logic                  w_take;

    // wrapping elapsed time against the stored lifetime
    assign w_elapsed   = i_time - r_start;
    assign w_timed_out = r_active && (r_life != '0) && (w_elapsed >= r_life);

    // slot state update
    always_comb begin
        n_active = r_active;
        n_start  = r_start;
        n_life   = r_life;
        if (i_ctrl.clear) begin
            n_active = IS_IDLE_SLOT;
        end
        if (i_ctrl.activate && i_ctrl.hit) begin
            n_active = 1'b1;
            n_start  = i_time;
            n_life   = i_dur;
        end
        if (i_ctrl.deactivate && i_ctrl.hit) begin
            n_active = 1'b0;
        end
        if (i_ctrl.expire && w_timed_out) begin
            n_active = 1'b0;
        end
        if (i_ctrl.set_idle && IS_IDLE_SLOT) begin
            n_active = 1'b1;
        end
    end

    // running best priority handed on to the next cell
    assign w_take = r_active && (i_prio > i_best);

    always_comb begin
        n_best = w_take ? i_prio : i_best;
        n_sel  = w_take ? SLOT_W'(CELL_IDX) : i_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= IS_IDLE_SLOT;
            r_life   <= '0;
        end else begin
            r_active <= n_active;
            r_life   <= n_life;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_best  <= n_best;
        r_sel   <= n_sel;
    end

    assign o_active = r_active;
    assign o_best   = r_best;
    assign o_sel    = r_sel;

endmodule

/* rtl/timed_priority_scene_selector.sv */
// Timed fixed-priority selector over NUM_SLOTS request slots kept in a chain
// of cells. Each input request carries op in tuser and slot, lifetime_ms and
// now_ms in tdata; each one gives exactly one result (chosen_scene,
// scene_moved). Activate, deactivate and clear-all requests go from acceptance
// straight to the done step, which loads the output register. An evaluate
// request is accepted, then expires timed slots in parallel, then brings back
// the idle slot if nothing is left, then sweeps while the best priority ripples
// through the cell chain one cell per cycle, and last loads the output
// register. o_s_tready is high only while the sequencer is idle, so the next
// request can be taken while a finished result still waits on the output side;
// that next request then holds in its last step until the output register is
// free. Priority writes are expected only while the block is idle.
`include "timed_priority_scene_selector_defines.svh"

module timed_priority_scene_selector
    import tpss_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // input requests
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // slot[3:0], lifetime_ms[35:4], now_ms[67:36]
    input  logic [OP_W-1:0]        i_s_tuser,   // op[1:0]
    // result requests
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // chosen_scene[3:0], scene_moved[4]
);

    localparam int CNT_W = $clog2(NUM_SLOTS);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] n_now;
    logic                  r_is_eval;
    logic                  n_is_eval;
    logic [SLOT_W-1:0]     r_cur;
    logic [SLOT_W-1:0]     n_cur;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [SLOT_W-1:0]     r_out_sel;
    logic [SLOT_W-1:0]     n_out_sel;
    logic                  r_out_chg;
    logic                  n_out_chg;
    logic [CFG_W-1:0]      r_prio_lo;
    logic [CFG_W-1:0]      r_prio_hi;

    logic                  w_in_accept;
    t_op                   w_op;
    logic [SLOT_W-1:0]     w_slot;
    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_dur;
    logic [TIME_WIDTH-1:0] w_time;
    logic [2*CFG_W-1:0]    w_prio_all;
    logic                  w_out_load;
    logic [SLOT_W-1:0]     w_new_sel;
    logic                  w_changed;
    t_cell_ctrl            w_ctrl   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  w_active;
    logic [PRIO_W-1:0]     w_best   [NUM_SLOTS];
    logic [SLOT_W-1:0]     w_sel    [NUM_SLOTS];

    // request field unpacking
    assign w_in_accept = i_s_tvalid && o_s_tready;
    assign w_op        = t_op'(i_s_tuser);
    assign w_slot      = i_s_tdata[SLOT_LSB +: SLOT_W];

    generate
        if (TIME_WIDTH <= FIELD_TIME_W) begin : g_time_narrow
            assign w_now = i_s_tdata[NOW_LSB +: TIME_WIDTH];
            assign w_dur = i_s_tdata[DUR_LSB +: TIME_WIDTH];
        end else begin : g_time_wide
            assign w_now = {{(TIME_WIDTH-FIELD_TIME_W){1'b0}},
                            i_s_tdata[NOW_LSB +: FIELD_TIME_W]};
            assign w_dur = {{(TIME_WIDTH-FIELD_TIME_W){1'b0}},
                            i_s_tdata[DUR_LSB +: FIELD_TIME_W]};
        end
    endgenerate

    // activate stamps with the live time, expiry uses the latched one
    assign w_time = (r_state == ST_IDLE) ? w_now : r_now;

    // priority registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_lo <= PRIO_LO_RESET;
            r_prio_hi <= PRIO_HI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRIO_LO: r_prio_lo <= i_cfg_wdata;
                CFG_PRIO_HI: r_prio_hi <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_prio_all = {r_prio_hi, r_prio_lo};

    // per-cell control
    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            w_ctrl[k].hit        = (w_slot == SLOT_W'(k));
            w_ctrl[k].activate   = w_in_accept && (w_op == OP_ACTIVATE);
            w_ctrl[k].deactivate = w_in_accept && (w_op == OP_DEACTIVATE);
            w_ctrl[k].clear      = w_in_accept && (w_op == OP_CLEAR);
            w_ctrl[k].expire     = (r_state == ST_EXPIRE);
            w_ctrl[k].set_idle   = (r_state == ST_FIXUP) && (w_active == '0);
        end
    end

    // cell chain, best priority travels from slot 0 upwards
    generate
        for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
            logic [PRIO_W-1:0] w_best_in;
            logic [SLOT_W-1:0] w_sel_in;

            if (g == 0) begin : g_head
                assign w_best_in = '0;
                assign w_sel_in  = '0;
            end else begin : g_link
                assign w_best_in = w_best[g-1];
                assign w_sel_in  = w_sel[g-1];
            end

            tpss_cell #(
                .TIME_WIDTH (TIME_WIDTH),
                .CELL_IDX   (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (w_ctrl[g]),
                .i_time   (w_time),
                .i_dur    (w_dur),
                .i_prio   (w_prio_all[g*PRIO_W +: PRIO_W]),
                .i_best   (w_best_in),
                .i_sel    (w_sel_in),
                .o_active (w_active[g]),
                .o_best   (w_best[g]),
                .o_sel    (w_sel[g])
            );
        end
    endgenerate

    // result of the sweep and output register handoff
    assign w_new_sel  = (w_best[NUM_SLOTS-1] == '0) ? '0 : w_sel[NUM_SLOTS-1];
    assign w_changed  = r_is_eval && (w_new_sel != r_cur);
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_now       = r_now;
        n_is_eval   = r_is_eval;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_out_sel   = r_out_sel;
        n_out_chg   = r_out_chg;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_now     = w_now;
                    n_is_eval = (w_op == OP_EVAL);
                    n_state   = (w_op == OP_EVAL) ? ST_EXPIRE : ST_DONE;
                end
            end
            ST_EXPIRE: begin
                n_state = ST_FIXUP;
            end
            ST_FIXUP: begin
                n_cnt   = '0;
                n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_SLOTS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_out_chg   = w_changed;
                    if (r_is_eval) begin
                        n_cur     = w_new_sel;
                        n_out_sel = w_new_sel;
                    end else begin
                        n_out_sel = r_cur;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_now     <= n_now;
        r_is_eval <= n_is_eval;
        r_out_sel <= n_out_sel;
        r_out_chg <= n_out_chg;
    end

    // ports
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_m_tdata                           = '0;
        o_m_tdata[OUT_SEL_LSB +: SLOT_W]    = r_out_sel;
        o_m_tdata[OUT_CHG_BIT]              = r_out_chg;
    end

    // checks
    `TPSS_ASSERT_IMP(a_sweep_has_active, i_clk, i_rst_n,
        r_state == ST_SWEEP, w_active != '0, "no slot active during sweep")
    `TPSS_ASSERT_IMP(a_out_in_range, i_clk, i_rst_n,
        r_out_valid, r_out_sel < SLOT_W'(NUM_SLOTS), "selected slot out of range")
    `TPSS_ASSERT_NEXT(a_change_moves_sel, i_clk, i_rst_n,
        w_out_load && w_changed, r_cur != $past(r_cur), "change flagged but selection kept")
    `TPSS_ASSERT_NEXT(a_cmd_keeps_sel, i_clk, i_rst_n,
        w_in_accept && (w_op != OP_EVAL), $stable(r_cur), "command request moved selection")
    `TPSS_ASSERT_IMP(a_zero_best_idle, i_clk, i_rst_n,
        (r_state == ST_DONE) && (w_best[NUM_SLOTS-1] == '0), w_sel[NUM_SLOTS-1] == '0,
        "zero priority chain picked a slot")

endmodule
